// ===== hdl/md5sh_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_pkg
// Shared types, constants and round tables for the MD5 stream hasher.
// ----------------------------------------------------------------------------
package md5sh_pkg;

  // chaining initial vector
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE   = 8'h80;
  localparam logic [7:0] MAGIC_BYTE = 8'h0e;
  localparam logic [3:0] MAX_DIGIT  = 4'd9;
  localparam logic [2:0] MAX_BYTES  = 3'd4;

  localparam int unsigned CFG_WIDTH = 64;
  localparam int unsigned CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_LOW  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VALUE_HIGH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_LOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MASK_HIGH  = 2'd3;

  localparam logic [3:0] LEN_WORD_LOW  = 4'd14;
  localparam logic [3:0] LEN_WORD_HIGH = 4'd15;

  // item kinds
  localparam logic KIND_ABSORB = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // sequencer states of the top level
  typedef enum logic [2:0] {
    S_IDLE,
    S_ABSORB,
    S_WAIT_ABS,
    S_PAD,
    S_WAIT_PAD,
    S_LEN,
    S_WAIT_LEN,
    S_EMIT
  } md5sh_state_t;

  // states of the round engine
  typedef enum logic [1:0] {
    CORE_IDLE,
    CORE_ROUND,
    CORE_FOLD
  } md5sh_core_state_t;

  // control from sequencer to round engine
  typedef struct packed {
    logic start;
    logic clear;
  } md5sh_ctl_t;

  // status from round engine to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } md5sh_sts_t;

  // message word index used by round r
  function automatic logic [3:0] msg_index(input logic [5:0] r);
    logic [3:0] g;
    unique case (r[5:4])
      2'd0: g = r[3:0];
      2'd1: g = 4'(r[3:0] * 4'd5 + 4'd1);
      2'd2: g = 4'(r[3:0] * 4'd3 + 4'd5);
      default: g = 4'(r[3:0] * 4'd7);
    endcase
    return g;
  endfunction

  // left-rotate amount of round r
  function automatic logic [4:0] rot_amount(input logic [5:0] r);
    logic [4:0] s;
    unique case ({r[5:4], r[1:0]})
      4'h0: s = 5'd7;
      4'h1: s = 5'd12;
      4'h2: s = 5'd17;
      4'h3: s = 5'd22;
      4'h4: s = 5'd5;
      4'h5: s = 5'd9;
      4'h6: s = 5'd14;
      4'h7: s = 5'd20;
      4'h8: s = 5'd4;
      4'h9: s = 5'd11;
      4'ha: s = 5'd16;
      4'hb: s = 5'd23;
      4'hc: s = 5'd6;
      4'hd: s = 5'd10;
      4'he: s = 5'd15;
      default: s = 5'd21;
    endcase
    return s;
  endfunction

  // additive constant of round r
  function automatic logic [31:0] round_const(input logic [5:0] r);
    logic [31:0] k;
    unique case (r)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/md5_stream_hasher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5_stream_hasher
// MD5 hasher: byte absorb, block buffer, padding sequencer and digest output.
// ----------------------------------------------------------------------------
// Bytes are taken one per cycle, except while a completed block is being
// compressed, so an absorb item holds in_stall high until its bytes (1 to 4)
// are all taken, and a new item is accepted only once the last is done. Each
// completed 64-byte block runs through the round engine, one round per
// cycle: 64 rounds plus a fold step, during which in_stall stays high. A
// finish item takes a pad step, a length step, one or two compressions
// (two when fewer than 9 bytes are free in the last block) and an emit
// step, all under in_stall; the emit waits while the previous digest still
// sits unread in the output register. After a finish the engine restarts
// from the initial vector.
// ----------------------------------------------------------------------------
module md5_stream_hasher (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  // configuration write port
  input  wire logic                                 cfg_write,
  input  wire logic [md5sh_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [md5sh_pkg::CFG_WIDTH-1:0]      cfg_data,
  // input channel
  input  wire logic                                 in_valid,
  output logic                                      in_stall,
  input  wire logic                                 kind,
  input  wire logic [31:0]                          data_word,
  input  wire logic [2:0]                           byte_count,
  // output channel
  output logic                                      out_valid,
  input  wire logic                                 out_stall,
  output logic      [63:0]                          digest_low,
  output logic      [63:0]                          digest_high,
  output logic                                      target_hit,
  output logic                                      magic_zero_e
);

  md5sh_pkg::md5sh_state_t state, state_next;
  md5sh_pkg::md5sh_ctl_t   core_ctl;
  md5sh_pkg::md5sh_sts_t   core_sts;

  logic [63:0] value_low, value_high, mask_low, mask_high;
  logic [31:0] msg_buf [16];
  logic [31:0] msg_buf_next [16];
  logic [63:0] byte_len;
  logic [31:0] data_reg;
  logic [2:0]  bytes_left;

  logic        in_xfer;
  logic        out_free;
  logic [5:0]  pos;
  logic [63:0] bit_len;
  logic [3:0]  msg_idx;
  logic [127:0] chain;

  logic        wr_byte;
  logic [7:0]  byte_val;
  logic        wr_len;
  logic        buf_clear;
  logic        byte_step;
  logic        eng_clear;
  logic        out_load;

  logic        hit_calc;
  logic        magic_calc;

  assign in_stall = (state != md5sh_pkg::S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign pos      = byte_len[5:0];
  assign bit_len  = {byte_len[60:0], 3'b000};

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      value_low  <= '0;
      value_high <= '0;
      mask_low   <= '0;
      mask_high  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        md5sh_pkg::REG_VALUE_LOW:  value_low  <= cfg_data;
        md5sh_pkg::REG_VALUE_HIGH: value_high <= cfg_data;
        md5sh_pkg::REG_MASK_LOW:   mask_low   <= cfg_data;
        md5sh_pkg::REG_MASK_HIGH:  mask_high  <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      md5sh_pkg::S_IDLE: begin
        if (in_xfer) begin
          if (kind == md5sh_pkg::KIND_FINISH) state_next = md5sh_pkg::S_PAD;
          else if (byte_count != 3'd0)        state_next = md5sh_pkg::S_ABSORB;
        end
      end
      md5sh_pkg::S_ABSORB: begin
        if (pos == 6'd63)            state_next = md5sh_pkg::S_WAIT_ABS;
        else if (bytes_left == 3'd1) state_next = md5sh_pkg::S_IDLE;
      end
      md5sh_pkg::S_WAIT_ABS: begin
        if (core_sts.done) begin
          state_next = (bytes_left == 3'd0) ? md5sh_pkg::S_IDLE : md5sh_pkg::S_ABSORB;
        end
      end
      md5sh_pkg::S_PAD: begin
        state_next = (pos[5:3] == 3'd7) ? md5sh_pkg::S_WAIT_PAD : md5sh_pkg::S_LEN;
      end
      md5sh_pkg::S_WAIT_PAD: if (core_sts.done) state_next = md5sh_pkg::S_LEN;
      md5sh_pkg::S_LEN:      state_next = md5sh_pkg::S_WAIT_LEN;
      md5sh_pkg::S_WAIT_LEN: if (core_sts.done) state_next = md5sh_pkg::S_EMIT;
      md5sh_pkg::S_EMIT:     if (out_free) state_next = md5sh_pkg::S_IDLE;
      default:               state_next = md5sh_pkg::S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    wr_byte        = 1'b0;
    byte_val       = data_reg[7:0];
    wr_len         = 1'b0;
    buf_clear      = 1'b0;
    byte_step      = 1'b0;
    eng_clear      = 1'b0;
    out_load       = 1'b0;
    core_ctl.start = 1'b0;
    unique case (state)
      md5sh_pkg::S_IDLE: ;
      md5sh_pkg::S_ABSORB: begin
        wr_byte        = 1'b1;
        byte_step      = 1'b1;
        core_ctl.start = (pos == 6'd63);
      end
      md5sh_pkg::S_WAIT_ABS: buf_clear = core_sts.done;
      md5sh_pkg::S_PAD: begin
        wr_byte        = 1'b1;
        byte_val       = md5sh_pkg::PAD_BYTE;
        core_ctl.start = (pos[5:3] == 3'd7);
      end
      md5sh_pkg::S_WAIT_PAD: buf_clear = core_sts.done;
      md5sh_pkg::S_LEN: begin
        wr_len         = 1'b1;
        core_ctl.start = 1'b1;
      end
      md5sh_pkg::S_WAIT_LEN: ;
      md5sh_pkg::S_EMIT: begin
        out_load  = out_free;
        buf_clear = out_free;
        eng_clear = out_free;
      end
      default: ;
    endcase
    core_ctl.clear = eng_clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5sh_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // item capture and byte walk
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      data_reg   <= data_word;
      bytes_left <= (byte_count > md5sh_pkg::MAX_BYTES) ? md5sh_pkg::MAX_BYTES : byte_count;
    end else if (byte_step) begin
      data_reg   <= {8'h00, data_reg[31:8]};
      bytes_left <= bytes_left - 3'd1;
    end
  end

  // message length in bytes
  always_ff @(posedge clk) begin
    if (rst || eng_clear) begin
      byte_len <= '0;
    end else if (byte_step) begin
      byte_len <= byte_len + 64'd1;
    end
  end

  // block buffer update
  always_comb begin
    for (int w = 0; w < 16; w++) begin
      msg_buf_next[w] = msg_buf[w];
      if (buf_clear) begin
        msg_buf_next[w] = '0;
      end else begin
        if (wr_byte && 4'(w) == pos[5:2]) begin
          for (int k = 0; k < 4; k++) begin
            if (2'(k) == pos[1:0]) msg_buf_next[w][8*k +: 8] = byte_val;
          end
        end
        if (wr_len && 4'(w) == md5sh_pkg::LEN_WORD_LOW)  msg_buf_next[w] = bit_len[31:0];
        if (wr_len && 4'(w) == md5sh_pkg::LEN_WORD_HIGH) msg_buf_next[w] = bit_len[63:32];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int w = 0; w < 16; w++) begin
      if (rst) msg_buf[w] <= '0;
      else     msg_buf[w] <= msg_buf_next[w];
    end
  end

  md5sh_core u_core (
    .clk      (clk),
    .rst      (rst),
    .ctl      (core_ctl),
    .msg_word (msg_buf[msg_idx]),
    .msg_idx  (msg_idx),
    .chain    (chain),
    .sts      (core_sts)
  );

  // digest flags
  always_comb begin
    hit_calc = (((chain[63:0] ^ value_low) & mask_low) == 64'd0) &&
               (((chain[127:64] ^ value_high) & mask_high) == 64'd0);
    magic_calc = (chain[7:0] == md5sh_pkg::MAGIC_BYTE);
    for (int i = 2; i < 32; i++) begin
      if (chain[4*i +: 4] > md5sh_pkg::MAX_DIGIT) magic_calc = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      digest_low   <= chain[63:0];
      digest_high  <= chain[127:64];
      target_hit   <= hit_calc;
      magic_zero_e <= magic_calc;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/md5sh_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_core
// Round engine: one MD5 round per cycle for 64 rounds, then a fold step
// that adds the working words into the chaining state.
// ----------------------------------------------------------------------------
module md5sh_core (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire md5sh_pkg::md5sh_ctl_t ctl,
  input  wire logic [31:0]          msg_word,
  output logic      [3:0]           msg_idx,
  output logic      [127:0]         chain,
  output md5sh_pkg::md5sh_sts_t     sts
);

  md5sh_pkg::md5sh_core_state_t state, state_next;

  logic [5:0]  round;
  logic [31:0] wa, wb, wc, wd;
  logic [31:0] chain_a, chain_b, chain_c, chain_d;

  logic [31:0] fmix;
  logic [31:0] sum;
  logic [63:0] rot_dbl;
  logic [31:0] rot;

  // round function
  always_comb begin
    unique case (round[5:4])
      2'd0: fmix = (wb & wc) | (~wb & wd);
      2'd1: fmix = (wd & wb) | (~wd & wc);
      2'd2: fmix = wb ^ wc ^ wd;
      default: fmix = wc ^ (wb | ~wd);
    endcase
  end

  assign msg_idx = md5sh_pkg::msg_index(round);
  assign sum     = wa + fmix + md5sh_pkg::round_const(round) + msg_word;
  assign rot_dbl = {sum, sum} << md5sh_pkg::rot_amount(round);
  assign rot     = rot_dbl[63:32];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      md5sh_pkg::CORE_IDLE:  if (ctl.start) state_next = md5sh_pkg::CORE_ROUND;
      md5sh_pkg::CORE_ROUND: if (round == 6'd63) state_next = md5sh_pkg::CORE_FOLD;
      md5sh_pkg::CORE_FOLD:  state_next = md5sh_pkg::CORE_IDLE;
      default:               state_next = md5sh_pkg::CORE_IDLE;
    endcase
  end

  // status
  always_comb begin
    sts.busy = (state != md5sh_pkg::CORE_IDLE);
    sts.done = (state == md5sh_pkg::CORE_FOLD);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= md5sh_pkg::CORE_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // working words and round counter
  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
    end else if (state == md5sh_pkg::CORE_IDLE && ctl.start) begin
      wa    <= chain_a;
      wb    <= chain_b;
      wc    <= chain_c;
      wd    <= chain_d;
      round <= '0;
    end else if (state == md5sh_pkg::CORE_ROUND) begin
      wa    <= wd;
      wd    <= wc;
      wc    <= wb;
      wb    <= wb + rot;
      round <= round + 6'd1;
    end
  end

  // chaining state
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      chain_a <= md5sh_pkg::IV_A;
      chain_b <= md5sh_pkg::IV_B;
      chain_c <= md5sh_pkg::IV_C;
      chain_d <= md5sh_pkg::IV_D;
    end else if (state == md5sh_pkg::CORE_FOLD) begin
      chain_a <= chain_a + wa;
      chain_b <= chain_b + wb;
      chain_c <= chain_c + wc;
      chain_d <= chain_d + wd;
    end
  end

  assign chain = {chain_d, chain_c, chain_b, chain_a};

endmodule
`default_nettype wire

// ===== hdl/md5sh_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// md5sh_checker
// Port-level checks of the MD5 stream hasher, bound to the top level.
// ----------------------------------------------------------------------------
module md5sh_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        cfg_write,
  input wire logic [1:0]  cfg_index,
  input wire logic [63:0] cfg_data,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        kind,
  input wire logic [31:0] data_word,
  input wire logic [2:0]  byte_count,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [63:0] digest_low,
  input wire logic [63:0] digest_high,
  input wire logic        target_hit,
  input wire logic        magic_zero_e
);

  logic in_xfer;
  assign in_xfer = in_valid && !in_stall;

  // a stalled result holds its digest
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(digest_low) && $stable(digest_high))
    else $error("stalled digest changed");

  // an item with work makes the block busy in the next cycle
  a_busy_after_item: assert property (@(posedge clk) disable iff (rst)
    in_xfer && (kind || byte_count != 3'd0) |=> in_stall)
    else $error("block took a new transfer while an item was at work");

  // a new result only appears while the block is busy finishing
  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a finish in progress");

  // an absorb transfer never yields a result right away
  a_absorb_no_result: assert property (@(posedge clk) disable iff (rst)
    in_xfer && !kind |=> !$rose(out_valid))
    else $error("absorb transfer produced a result");

endmodule

bind md5_stream_hasher md5sh_checker u_md5sh_checker (.*);
`default_nettype wire

// ===== tb/md5_digest_checker.sv =====
// ----------------------------------------------------------------------------
// md5_digest_checker
// Watches the hasher's ports, computes every digest on its own and compares.
// ----------------------------------------------------------------------------
// Each accepted absorb transfer is folded into a private MD5 state. Each
// accepted finish transfer pads the message, yields the expected digest and
// both flags, and queues them. Each accepted output transfer is compared
// field by field with the oldest queued digest. Target registers are tracked
// from the write port.
// ----------------------------------------------------------------------------
module md5_digest_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_write,
  input  logic [md5sh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [md5sh_pkg::CFG_WIDTH-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic                            kind,
  input  logic [31:0]                     data_word,
  input  logic [2:0]                      byte_count,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [63:0]                     digest_low,
  input  logic [63:0]                     digest_high,
  input  logic                            target_hit,
  input  logic                            magic_zero_e,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [63:0] low;
    logic [63:0] high;
    logic        hit;
    logic        magic;
  } digest_t;

  // per-round additive constants
  logic [31:0] round_k [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};

  // rotate amounts, four per round group
  int unsigned shift_by [16] = '{7, 12, 17, 22, 5, 9, 14, 20,
                                 4, 11, 16, 23, 6, 10, 15, 21};

  logic [31:0] chain [4];
  logic [31:0] blk [16];
  logic [63:0] msg_len;
  logic [63:0] value_lo, value_hi, mask_lo, mask_hi;
  digest_t     expected_digests [$];
  int          digest_no;

  // back to the initial vector with an empty message
  function automatic void restart_engine();
    chain[0] = md5sh_pkg::IV_A;
    chain[1] = md5sh_pkg::IV_B;
    chain[2] = md5sh_pkg::IV_C;
    chain[3] = md5sh_pkg::IV_D;
    blk = '{default: '0};
    msg_len = '0;
  endfunction

  // 64-round compression of the block buffer into the chain
  function automatic void fold_block();
    logic [31:0] a, b, c, d, f, sum;
    int unsigned r, g, s;
    a = chain[0];
    b = chain[1];
    c = chain[2];
    d = chain[3];
    for (r = 0; r < 64; r++) begin
      case (r / 16)
        0: begin
          f = (b & c) | (~b & d);
          g = r;
        end
        1: begin
          f = (d & b) | (~d & c);
          g = (5 * r + 1) % 16;
        end
        2: begin
          f = b ^ c ^ d;
          g = (3 * r + 5) % 16;
        end
        default: begin
          f = c ^ (b | ~d);
          g = (7 * r) % 16;
        end
      endcase
      sum = a + f + round_k[r] + blk[g];
      s = shift_by[(r / 16) * 4 + r % 4];
      a = d;
      d = c;
      c = b;
      b = b + ((sum << s) | (sum >> (32 - s)));
    end
    chain[0] += a;
    chain[1] += b;
    chain[2] += c;
    chain[3] += d;
    blk = '{default: '0};
  endfunction

  function automatic void put_byte(input logic [5:0] pos, input logic [7:0] v);
    blk[pos[5:2]][8 * pos[1:0] +: 8] = v;
  endfunction

  // append up to four bytes, compressing whenever the block fills
  function automatic void absorb_word(input logic [31:0] data, input logic [2:0] count);
    int unsigned n, i;
    logic [5:0] pos;
    n = (count > md5sh_pkg::MAX_BYTES) ? md5sh_pkg::MAX_BYTES : count;
    for (i = 0; i < n; i++) begin
      pos = msg_len[5:0];
      put_byte(pos, data[8 * i +: 8]);
      msg_len = msg_len + 1;
      if (pos == 6'd63) begin
        fold_block();
      end
    end
  endfunction

  // pad, append the bit length, compress and derive both flags
  function automatic digest_t finish_message();
    digest_t     res;
    logic [5:0]  pos;
    logic [63:0] bit_len;
    logic [127:0] full;
    int unsigned i;
    pos = msg_len[5:0];
    put_byte(pos, md5sh_pkg::PAD_BYTE);
    if (pos >= 6'd56) begin
      fold_block();
    end
    bit_len = msg_len << 3;
    blk[md5sh_pkg::LEN_WORD_LOW]  = bit_len[31:0];
    blk[md5sh_pkg::LEN_WORD_HIGH] = bit_len[63:32];
    fold_block();
    res.low  = {chain[1], chain[0]};
    res.high = {chain[3], chain[2]};
    full = {res.high, res.low};
    res.magic = (full[7:0] == md5sh_pkg::MAGIC_BYTE);
    for (i = 2; i < 32; i++) begin
      if (full[4 * i +: 4] > md5sh_pkg::MAX_DIGIT) begin
        res.magic = 1'b0;
      end
    end
    res.hit = (((res.low ^ value_lo) & mask_lo) == '0) &&
              (((res.high ^ value_hi) & mask_hi) == '0);
    restart_engine();
    return res;
  endfunction

  task automatic report_mismatch(input string line);
    $display("[%0t] mismatch: %s", $realtime, line);
    fail_count++;
  endtask

  // watch the ports
  always @(posedge clk) begin
    digest_t want;
    if (rst) begin
      restart_engine();
      value_lo = '0;
      value_hi = '0;
      mask_lo = '0;
      mask_hi = '0;
      expected_digests.delete();
      digest_no = 0;
      pending <= 0;
    end else begin
      // register writes
      if (cfg_write) begin
        case (cfg_index)
          md5sh_pkg::REG_VALUE_LOW:  value_lo = cfg_data;
          md5sh_pkg::REG_VALUE_HIGH: value_hi = cfg_data;
          md5sh_pkg::REG_MASK_LOW:   mask_lo = cfg_data;
          default:                   mask_hi = cfg_data;
        endcase
      end
      // output transfer against oldest expected digest
      if (out_valid && !out_stall) begin
        if (expected_digests.size() == 0) begin
          report_mismatch($sformatf("digest %h%h with none expected",
                                    digest_high, digest_low));
        end else begin
          want = expected_digests.pop_front();
          if (digest_low !== want.low)
            report_mismatch($sformatf("digest %0d digest_low got %h want %h",
                                      digest_no, digest_low, want.low));
          if (digest_high !== want.high)
            report_mismatch($sformatf("digest %0d digest_high got %h want %h",
                                      digest_no, digest_high, want.high));
          if (target_hit !== want.hit)
            report_mismatch($sformatf("digest %0d target_hit got %b want %b",
                                      digest_no, target_hit, want.hit));
          if (magic_zero_e !== want.magic)
            report_mismatch($sformatf("digest %0d magic_zero_e got %b want %b",
                                      digest_no, magic_zero_e, want.magic));
        end
        digest_no++;
      end
      // input transfer
      if (in_valid && !in_stall) begin
        if (kind == md5sh_pkg::KIND_FINISH) begin
          expected_digests.push_back(finish_message());
        end else begin
          absorb_word(data_word, byte_count);
        end
      end
      pending <= expected_digests.size();
    end
  end

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Stimulus and verdict for the MD5 stream hasher.
// ----------------------------------------------------------------------------
// A directed message set (empty message, several byte counts, a block boundary
// inside a transfer) runs first, then random messages under four target
// settings. Both sides idle at random; the receiver holds off once for a long
// stretch so the hasher backs up. The checker beside the block does all
// prediction and comparison.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic                            clk;
  logic                            rst;
  logic                            cfg_write;
  logic [md5sh_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [md5sh_pkg::CFG_WIDTH-1:0] cfg_data;
  logic                            in_valid;
  logic                            in_stall;
  logic                            kind;
  logic [31:0]                     data_word;
  logic [2:0]                      byte_count;
  logic                            out_valid;
  logic                            out_stall;
  logic [63:0]                     digest_low;
  logic [63:0]                     digest_high;
  logic                            target_hit;
  logic                            magic_zero_e;
  int                              fail_count;
  int                              pending;

  bit hold_req;
  bit calm;
  int sent_items;

  // digest of the empty message, little-endian halves
  localparam logic [63:0] EMPTY_LOW  = 64'h04b2008fd98c1dd4;
  localparam logic [63:0] EMPTY_HIGH = 64'h7e42f8ec980980e9;

  md5_stream_hasher i_dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_low   (digest_low),
    .digest_high  (digest_high),
    .target_hit   (target_hit),
    .magic_zero_e (magic_zero_e)
  );

  md5_digest_checker u_digest_check (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .kind         (kind),
    .data_word    (data_word),
    .byte_count   (byte_count),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_low   (digest_low),
    .digest_high  (digest_high),
    .target_hit   (target_hit),
    .magic_zero_e (magic_zero_e),
    .fail_count   (fail_count),
    .pending      (pending)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit
  initial begin
    #2_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 36);
        @(posedge clk);
      end
    end
  end

  // one input transfer, with random idle cycles ahead of it
  task automatic send_item(input logic k, input logic [31:0] data, input logic [2:0] count);
    while (!calm && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    kind       <= k;
    data_word  <= data;
    byte_count <= count;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (k == md5sh_pkg::KIND_FINISH || count != 3'd0) sent_items++;
  endtask

  // absorb transfers with random bytes, then a finish
  task automatic send_message(input int n_words);
    int roll;
    logic [2:0] count;
    for (int i = 0; i < n_words; i++) begin
      roll = $urandom_range(99);
      if (roll < 5) count = 3'd0;
      else if (roll < 10) count = 3'($urandom_range(5, 7));
      else count = 3'($urandom_range(1, 4));
      send_item(md5sh_pkg::KIND_ABSORB, $urandom, count);
    end
    send_item(md5sh_pkg::KIND_FINISH, $urandom, 3'($urandom_range(7)));
  endtask

  // random message lengths, some crossing one or more block boundaries
  task automatic run_messages(input int n_items);
    int goal, roll;
    goal = sent_items + n_items;
    while (sent_items < goal) begin
      roll = $urandom_range(99);
      if (roll < 10) send_message(0);
      else if (roll < 75) send_message($urandom_range(1, 20));
      else send_message($urandom_range(14, 40));
    end
  endtask

  // stop sending until every digest is out and the engine is quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic write_reg(input logic [md5sh_pkg::CFG_IDX_W-1:0] idx,
                           input logic [md5sh_pkg::CFG_WIDTH-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic load_target(input logic [63:0] v_lo, input logic [63:0] v_hi,
                             input logic [63:0] m_lo, input logic [63:0] m_hi);
    write_reg(md5sh_pkg::REG_VALUE_LOW, v_lo);
    write_reg(md5sh_pkg::REG_VALUE_HIGH, v_hi);
    write_reg(md5sh_pkg::REG_MASK_LOW, m_lo);
    write_reg(md5sh_pkg::REG_MASK_HIGH, m_hi);
    cfg_write <= 1'b0;
  endtask

  // stimulus
  initial begin
    rst        <= 1'b1;
    cfg_write  <= 1'b0;
    cfg_index  <= md5sh_pkg::REG_VALUE_LOW;
    cfg_data   <= '0;
    in_valid   <= 1'b0;
    kind       <= md5sh_pkg::KIND_ABSORB;
    data_word  <= '0;
    byte_count <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // reset targets (zero masks): empty message, finish fields ignored
    send_item(md5sh_pkg::KIND_FINISH, 32'hffffffff, 3'd7);
    // byte counts: one, full, zero, oversized, three
    send_item(md5sh_pkg::KIND_ABSORB, 32'h00000000, 3'd1);
    send_item(md5sh_pkg::KIND_ABSORB, 32'hffffffff, 3'd4);
    send_item(md5sh_pkg::KIND_ABSORB, 32'hffffffff, 3'd0);
    send_item(md5sh_pkg::KIND_ABSORB, $urandom, 3'd7);
    send_item(md5sh_pkg::KIND_ABSORB, $urandom, 3'd3);
    send_item(md5sh_pkg::KIND_FINISH, $urandom, 3'd0);
    // 63 bytes, then a transfer that completes the block and spills over
    send_item(md5sh_pkg::KIND_ABSORB, $urandom, 3'd3);
    repeat (15) send_item(md5sh_pkg::KIND_ABSORB, $urandom, 3'd4);
    send_item(md5sh_pkg::KIND_ABSORB, $urandom, 3'd4);
    send_item(md5sh_pkg::KIND_FINISH, $urandom, 3'd4);

    // exact match on the empty digest, full masks, no idling at first
    settle();
    load_target(EMPTY_LOW, EMPTY_HIGH, '1, '1);
    calm = 1'b1;
    send_item(md5sh_pkg::KIND_FINISH, $urandom, 3'd1);
    run_messages(120);
    calm = 1'b0;
    run_messages(120);

    // all-ones target under full masks
    settle();
    load_target('1, '1, '1, '1);
    run_messages(240);

    // single-bit masks; receiver backs up the hasher first
    settle();
    load_target({$urandom, $urandom}, {$urandom, $urandom},
                64'd1 << $urandom_range(63), 64'd1 << $urandom_range(63));
    hold_req = 1'b1;
    calm = 1'b1;
    repeat (6) send_message(1);
    calm = 1'b0;
    run_messages(240);

    // low half only
    settle();
    load_target({$urandom, $urandom}, {$urandom, $urandom},
                64'd1 << $urandom_range(63), '0);
    run_messages(240);

    settle();
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
